// ===== rtl/color_grade_matrix_gains_macros.svh =====
// assertion helpers shared by the checker
`ifndef COLOR_GRADE_MATRIX_GAINS_MACROS_SVH
`define COLOR_GRADE_MATRIX_GAINS_MACROS_SVH

// same-cycle implication, off while reset is held
`define CGMG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgmg: implication check failed");

// consequent expected a fixed number of cycles later
`define CGMG_ASSERT_DELAY(label, clk, rst_n, ante, cons, dly) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("cgmg: delayed check failed");

`endif

// ===== rtl/cgmg_pkg.sv =====
package cgmg_pkg;

  localparam int GAIN_FRAC_BITS = 12;
  localparam int GAIN_W         = 16;
  localparam int CH_W           = 8;

  // a1*c1 + a2*c2 and its square sum
  localparam int S_W       = 2 * CH_W + 1;
  localparam int SQ_W      = 2 * S_W;
  localparam int SUMSQ_W   = SQ_W + 2;
  localparam int RAD_SHIFT = 20;
  localparam int RAD_W     = SUMSQ_W + RAD_SHIFT;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int LEN_W     = ROOT_W;

  // normalized share, Q16 with headroom
  localparam int QUO_W    = 17;
  localparam int K_WIDE   = 25;
  localparam int K_NARROW = 26;
  localparam int NUM_W    = S_W + K_NARROW + 1;

  // alpha divisor shifts
  localparam int DSH_WIDE   = 8;
  localparam int DSH_NARROW = 7;

  // mode 0 scale: prior * (1500*2^16 + 1732*n) / (2500*2^16)
  localparam int SCALE_MUL_W = 11;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_W'(1732);
  localparam int SCALE_T_W   = QUO_W + SCALE_MUL_W;
  localparam int SCALE_U_W   = SCALE_T_W + 1;
  localparam logic [SCALE_U_W-1:0] SCALE_BASE = SCALE_U_W'(1500 * 65536);
  localparam int SCALE_NUM_W = GAIN_W + SCALE_U_W;
  localparam logic [SCALE_NUM_W-1:0] SCALE_HALF = SCALE_NUM_W'(1250 * 65536);
  // 2500*2^16 = 625 * 2^18: shift, then reciprocal multiply by 1/625
  localparam int DEN_SHIFT   = 18;
  localparam int SCALE_Y_W   = SCALE_NUM_W - DEN_SHIFT;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(109951163);
  localparam int RECIP_SHIFT = 36;
  localparam int PROD_W      = SCALE_Y_W + RECIP_W;
  localparam int SCALE_Q_W   = PROD_W - RECIP_SHIFT;

  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W + QUO_W + BACK_STAGES;

  localparam logic [GAIN_W-1:0] IDENT_GAIN =
    (GAIN_FRAC_BITS >= GAIN_W) ? {GAIN_W{1'b1}} : GAIN_W'(64'd1 << GAIN_FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_NORM   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_WEIGHT = 2'd2,
    MODE_IDENT  = 2'd3
  } mode_e;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ALPHA  = 1'b1;

  // per-request payload carried alongside the arithmetic
  typedef struct packed {
    mode_e                       mode;
    logic                        wide;
    logic [2:0][S_W-1:0]         s;
    logic [2:0][GAIN_W-1:0]      prior;
    logic [2:0][GAIN_W-1:0]      alt;
  } item_t;

endpackage

// ===== rtl/cgmg_front.sv =====
module cgmg_front import cgmg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  mode_e                   mode_i,
  input  logic                    wide_i,
  input  logic [2:0][CH_W-1:0]    c1_i,
  input  logic [2:0][CH_W-1:0]    c2_i,
  input  logic [CH_W-1:0]         a1_i,
  input  logic [CH_W-1:0]         a2_i,
  input  logic [2:0][GAIN_W-1:0]  prior_i,
  output logic                    vld_o,
  output item_t                   item_o,
  output logic [SUMSQ_W-1:0]      sumsq_o
);

  localparam int ALT_W = S_W + GAIN_FRAC_BITS + 2;
  localparam int ADD_SH_WIDE   = 7 + DSH_WIDE;
  localparam int ADD_SH_NARROW = 7 + DSH_NARROW;
  localparam int WGT_SH_WIDE   = 8 + DSH_WIDE;
  localparam int WGT_SH_NARROW = 8 + DSH_NARROW;
  localparam logic [ALT_W-1:0] ALT_MAX = ALT_W'({GAIN_W{1'b1}});

  // stage 1
  logic                   v1_q;
  mode_e                  mode1_q;
  logic                   wide1_q;
  logic [2:0][S_W-1:0]    s1_d, s1_q, m1_d, m1_q;
  logic [2:0][GAIN_W-1:0] prior1_q;
  // stage 2
  logic                   v2_q;
  item_t                  item2_d, item2_q;
  logic [2:0][SQ_W-1:0]   sq2_d, sq2_q;
  // stage 3
  logic                   v3_q;
  item_t                  item3_q;
  logic [SUMSQ_W-1:0]     sumsq3_d, sumsq3_q;

  logic [ALT_W-1:0] add_v [3];
  logic [ALT_W-1:0] add_r [3];
  logic [ALT_W-1:0] wgt_v [3];
  logic [ALT_W-1:0] wgt_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_d[i] = S_W'(a1_i) * S_W'(c1_i[i]) + S_W'(a2_i) * S_W'(c2_i[i]);
      m1_d[i] = (wide_i ? (S_W'(c1_i[i]) << DSH_WIDE) : (S_W'(c1_i[i]) << DSH_NARROW))
              + S_W'(a2_i) * S_W'(c2_i[i]);
    end
  end

  // additive, weighted and identity gains, plus the squares for the length
  always_comb begin
    item2_d.mode  = mode1_q;
    item2_d.wide  = wide1_q;
    item2_d.s     = s1_q;
    item2_d.prior = prior1_q;
    for (int i = 0; i < 3; i++) begin
      add_v[i] = (ALT_W'(m1_q[i]) << GAIN_FRAC_BITS)
               + (wide1_q ? (ALT_W'(1) << (ADD_SH_WIDE - 1))
                          : (ALT_W'(1) << (ADD_SH_NARROW - 1)));
      add_r[i] = wide1_q ? (add_v[i] >> ADD_SH_WIDE) : (add_v[i] >> ADD_SH_NARROW);
      wgt_v[i] = wide1_q
               ? (((ALT_W'(1) << WGT_SH_WIDE) + ALT_W'(s1_q[i])) << GAIN_FRAC_BITS)
                 + (ALT_W'(1) << (WGT_SH_WIDE - 1))
               : (((ALT_W'(1) << WGT_SH_NARROW) + ALT_W'(s1_q[i])) << GAIN_FRAC_BITS)
                 + (ALT_W'(1) << (WGT_SH_NARROW - 1));
      wgt_r[i] = wide1_q ? (wgt_v[i] >> WGT_SH_WIDE) : (wgt_v[i] >> WGT_SH_NARROW);
      unique case (mode1_q)
        MODE_ADD:    item2_d.alt[i] = (add_r[i] > ALT_MAX) ? {GAIN_W{1'b1}}
                                                            : add_r[i][GAIN_W-1:0];
        MODE_WEIGHT: item2_d.alt[i] = (wgt_r[i] > ALT_MAX) ? {GAIN_W{1'b1}}
                                                            : wgt_r[i][GAIN_W-1:0];
        MODE_IDENT:  item2_d.alt[i] = IDENT_GAIN;
        MODE_NORM:   item2_d.alt[i] = '0;
        default:     item2_d.alt[i] = '0;
      endcase
      sq2_d[i] = SQ_W'(s1_q[i]) * SQ_W'(s1_q[i]);
    end
  end

  assign sumsq3_d = SUMSQ_W'(sq2_q[0]) + SUMSQ_W'(sq2_q[1]) + SUMSQ_W'(sq2_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q  <= mode_i;
    wide1_q  <= wide_i;
    s1_q     <= s1_d;
    m1_q     <= m1_d;
    prior1_q <= prior_i;
    item2_q  <= item2_d;
    sq2_q    <= sq2_d;
    item3_q  <= item2_q;
    sumsq3_q <= sumsq3_d;
  end

  assign vld_o   = v3_q;
  assign item_o  = item3_q;
  assign sumsq_o = sumsq3_q;

endmodule

// ===== rtl/cgmg_sqrt.sv =====
module cgmg_sqrt import cgmg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  item_t              item_i,
  input  logic [SUMSQ_W-1:0] sumsq_i,
  output logic               vld_o,
  output item_t              item_o,
  output logic [LEN_W-1:0]   len_o
);

  // one root bit per stage, radicand is sumsq shifted up by RAD_SHIFT
  logic [ROOT_W:0]   rem_q  [ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic              vld_q  [ROOT_W];
  item_t             item_q [ROOT_W];

  logic [ROOT_W:0]   rem_in  [ROOT_W];
  logic [RAD_W-1:0]  rad_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [ROOT_W+2:0] cur_w   [ROOT_W];
  logic [ROOT_W+2:0] trial_w [ROOT_W];
  logic              ge_w    [ROOT_W];
  logic [ROOT_W:0]   rem_nx  [ROOT_W];
  logic [ROOT_W-1:0] root_nx [ROOT_W];

  always_comb begin
    rem_in[0]  = '0;
    rad_in[0]  = RAD_W'(sumsq_i) << RAD_SHIFT;
    root_in[0] = '0;
    for (int j = 1; j < ROOT_W; j++) begin
      rem_in[j]  = rem_q[j-1];
      rad_in[j]  = rad_q[j-1];
      root_in[j] = root_q[j-1];
    end
    for (int j = 0; j < ROOT_W; j++) begin
      cur_w[j]   = {rem_in[j], rad_in[j][RAD_W-1 -: 2]};
      trial_w[j] = {1'b0, root_in[j], 2'b01};
      ge_w[j]    = (cur_w[j] >= trial_w[j]);
      rem_nx[j]  = ge_w[j] ? ROOT_W'(cur_w[j] - trial_w[j]) + (ROOT_W+1)'(0)
                           : cur_w[j][ROOT_W:0];
      root_nx[j] = {root_in[j][ROOT_W-2:0], ge_w[j]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ROOT_W; j++) vld_q[j] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      for (int j = 1; j < ROOT_W; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    item_q[0] <= item_i;
    for (int j = 1; j < ROOT_W; j++) item_q[j] <= item_q[j-1];
    for (int j = 0; j < ROOT_W; j++) root_q[j] <= root_nx[j];
    for (int j = 0; j < ROOT_W - 1; j++) begin
      rem_q[j] <= rem_nx[j];
      rad_q[j] <= rad_in[j] << 2;
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign item_o = item_q[ROOT_W-1];
  assign len_o  = root_q[ROOT_W-1];

endmodule

// ===== rtl/cgmg_div.sv =====
module cgmg_div import cgmg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  item_t                 item_i,
  input  logic [LEN_W-1:0]      len_i,
  output logic                  vld_o,
  output item_t                 item_o,
  output logic [2:0][QUO_W-1:0] share_o
);

  // restoring divide, one quotient bit per stage for all three channels;
  // qn holds the numerator bits still to come on top, quotient bits below
  logic [2:0][LEN_W-1:0] rem_q [QUO_W-1];
  logic [LEN_W-1:0]      len_q [QUO_W-1];
  logic [2:0][QUO_W-1:0] qn_q  [QUO_W];
  logic                  lz_q  [QUO_W];
  logic                  vld_q [QUO_W];
  item_t                 item_q[QUO_W];

  logic [2:0][NUM_W-1:0] num_w;
  logic [2:0][LEN_W-1:0] rem_in [QUO_W];
  logic [LEN_W-1:0]      len_in [QUO_W];
  logic [2:0][QUO_W-1:0] qn_in  [QUO_W];
  logic [2:0][LEN_W:0]   cur_w  [QUO_W];
  logic [2:0]            ge_w   [QUO_W];
  logic [2:0][LEN_W-1:0] rem_nx [QUO_W];
  logic [2:0][QUO_W-1:0] qn_nx  [QUO_W];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_w[c] = (item_i.wide ? (NUM_W'(item_i.s[c]) << K_WIDE)
                              : (NUM_W'(item_i.s[c]) << K_NARROW))
               + NUM_W'(len_i >> 1);
      rem_in[0][c] = LEN_W'(num_w[c] >> QUO_W);
      qn_in[0][c]  = num_w[c][QUO_W-1:0];
    end
    len_in[0] = len_i;
    for (int j = 1; j < QUO_W; j++) begin
      rem_in[j] = rem_q[j-1];
      len_in[j] = len_q[j-1];
      qn_in[j]  = qn_q[j-1];
    end
    for (int j = 0; j < QUO_W; j++) begin
      for (int c = 0; c < 3; c++) begin
        cur_w[j][c]  = {rem_in[j][c], qn_in[j][c][QUO_W-1]};
        ge_w[j][c]   = (cur_w[j][c] >= {1'b0, len_in[j]});
        rem_nx[j][c] = ge_w[j][c] ? LEN_W'(cur_w[j][c] - {1'b0, len_in[j]})
                                  : cur_w[j][c][LEN_W-1:0];
        qn_nx[j][c]  = {qn_in[j][c][QUO_W-2:0], ge_w[j][c]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < QUO_W; j++) vld_q[j] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      for (int j = 1; j < QUO_W; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    item_q[0] <= item_i;
    lz_q[0]   <= (len_i == '0);
    for (int j = 1; j < QUO_W; j++) begin
      item_q[j] <= item_q[j-1];
      lz_q[j]   <= lz_q[j-1];
    end
    for (int j = 0; j < QUO_W; j++) qn_q[j] <= qn_nx[j];
    for (int j = 0; j < QUO_W - 1; j++) begin
      rem_q[j] <= rem_nx[j];
      len_q[j] <= len_in[j];
    end
  end

  // zero-length tint sum gives a zero share
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      share_o[c] = lz_q[QUO_W-1] ? '0 : qn_q[QUO_W-1][c];
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign item_o = item_q[QUO_W-1];

endmodule

// ===== rtl/cgmg_back.sv =====
module cgmg_back import cgmg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  item_t                  item_i,
  input  logic [2:0][QUO_W-1:0]  share_i,
  output logic                   done_o,
  output logic [2:0][GAIN_W-1:0] gains_o,
  output logic                   clear_o
);

  logic                        v1_q, v2_q, v3_q;
  item_t                       item1_q, item2_q, item3_q;
  logic [2:0][SCALE_T_W-1:0]   t1_d, t1_q;
  logic [2:0][SCALE_U_W-1:0]   u2_w;
  logic [2:0][SCALE_NUM_W-1:0] num2_d, num2_q;
  logic [2:0][SCALE_Y_W-1:0]   y3_d, y3_q;
  logic [2:0][PROD_W-1:0]      prod_w;
  logic [2:0][SCALE_Q_W-1:0]   q_w;
  logic [2:0][GAIN_W-1:0]      gains_d, gains_q;
  logic                        done_q, clear_d, clear_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t1_d[c]   = SCALE_T_W'(SCALE_MUL) * SCALE_T_W'(share_i[c]);
      u2_w[c]   = SCALE_U_W'(t1_q[c]) + SCALE_BASE;
      num2_d[c] = SCALE_NUM_W'(item1_q.prior[c]) * SCALE_NUM_W'(u2_w[c]);
      y3_d[c]   = SCALE_Y_W'((num2_q[c] + SCALE_HALF) >> DEN_SHIFT);
      // floor(y / 625) by reciprocal, exact over the whole y range
      prod_w[c] = PROD_W'(y3_q[c]) * PROD_W'(RECIP_M);
      q_w[c]    = prod_w[c][PROD_W-1:RECIP_SHIFT];
      if (item3_q.mode == MODE_NORM) begin
        gains_d[c] = (q_w[c] > SCALE_Q_W'({GAIN_W{1'b1}})) ? {GAIN_W{1'b1}}
                                                           : q_w[c][GAIN_W-1:0];
      end else begin
        gains_d[c] = item3_q.alt[c];
      end
    end
    clear_d = (item3_q.mode != MODE_NORM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      done_q  <= 1'b0;
      gains_q <= '0;
      clear_q <= 1'b0;
    end else begin
      v1_q   <= vld_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
      if (v3_q) begin
        gains_q <= gains_d;
        clear_q <= clear_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item1_q <= item_i;
    item2_q <= item1_q;
    item3_q <= item2_q;
    t1_q    <= t1_d;
    num2_q  <= num2_d;
    y3_q    <= y3_d;
  end

  assign done_o  = done_q;
  assign gains_o = gains_q;
  assign clear_o = clear_q;

endmodule

// ===== rtl/color_grade_matrix_gains.sv =====
// Colour-grading diagonal gain unit. Takes a request whenever start is high, every cycle,
// and returns its three Q4.12 gains with done_o, one result per request in request
// order; done_o is a single-cycle strobe and the outputs hold until the next one, so the
// receiver must capture them on the strobe. busy stays low. The pipeline holds the 28-stage
// bit-per-stage square root of the tint length and the 17-stage restoring divider of the
// normalized share, with three stages ahead (products, squares, sum) and four behind
// (gain scale and saturation). Configuration is written with cfg_we_i while no request
// is in flight and is sampled per request.
module color_grade_matrix_gains import cgmg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [CH_W-1:0]       tint_one_red_i,
  input  logic [CH_W-1:0]       tint_one_green_i,
  input  logic [CH_W-1:0]       tint_one_blue_i,
  input  logic [CH_W-1:0]       tint_one_alpha_i,
  input  logic [CH_W-1:0]       tint_two_red_i,
  input  logic [CH_W-1:0]       tint_two_green_i,
  input  logic [CH_W-1:0]       tint_two_blue_i,
  input  logic [CH_W-1:0]       tint_two_alpha_i,
  input  logic [GAIN_W-1:0]     prior_red_gain_i,
  input  logic [GAIN_W-1:0]     prior_green_gain_i,
  input  logic [GAIN_W-1:0]     prior_blue_gain_i,
  output logic                  done_o,
  output logic [GAIN_W-1:0]     red_gain_o,
  output logic [GAIN_W-1:0]     green_gain_o,
  output logic [GAIN_W-1:0]     blue_gain_o,
  output logic                  clear_cross_terms_o
);

  mode_e mode_d, mode_q;
  logic  wide_d, wide_q;

  logic                   req_vld;
  logic [2:0][CH_W-1:0]   c1, c2;
  logic [2:0][GAIN_W-1:0] prior;

  logic                   fr_vld;
  item_t                  fr_item;
  logic [SUMSQ_W-1:0]     fr_sumsq;
  logic                   sq_vld;
  item_t                  sq_item;
  logic [LEN_W-1:0]       sq_len;
  logic                   dv_vld;
  item_t                  dv_item;
  logic [2:0][QUO_W-1:0]  dv_share;
  logic [2:0][GAIN_W-1:0] gains;

  always_comb begin
    mode_d = mode_q;
    wide_d = wide_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_MODE: mode_d = mode_e'(cfg_data_i);
        CFG_WIDE_ALPHA:  wide_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORM;
      wide_q <= 1'b1;
    end else begin
      mode_q <= mode_d;
      wide_q <= wide_d;
    end
  end

  assign busy    = 1'b0;
  assign req_vld = start && !busy;
  assign c1      = {tint_one_blue_i, tint_one_green_i, tint_one_red_i};
  assign c2      = {tint_two_blue_i, tint_two_green_i, tint_two_red_i};
  assign prior   = {prior_blue_gain_i, prior_green_gain_i, prior_red_gain_i};

  cgmg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (req_vld),
    .mode_i  (mode_q),
    .wide_i  (wide_q),
    .c1_i    (c1),
    .c2_i    (c2),
    .a1_i    (tint_one_alpha_i),
    .a2_i    (tint_two_alpha_i),
    .prior_i (prior),
    .vld_o   (fr_vld),
    .item_o  (fr_item),
    .sumsq_o (fr_sumsq)
  );

  cgmg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (fr_vld),
    .item_i  (fr_item),
    .sumsq_i (fr_sumsq),
    .vld_o   (sq_vld),
    .item_o  (sq_item),
    .len_o   (sq_len)
  );

  cgmg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (sq_vld),
    .item_i  (sq_item),
    .len_i   (sq_len),
    .vld_o   (dv_vld),
    .item_o  (dv_item),
    .share_o (dv_share)
  );

  cgmg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (dv_vld),
    .item_i  (dv_item),
    .share_i (dv_share),
    .done_o  (done_o),
    .gains_o (gains),
    .clear_o (clear_cross_terms_o)
  );

  assign red_gain_o   = gains[0];
  assign green_gain_o = gains[1];
  assign blue_gain_o  = gains[2];

endmodule

// ===== rtl/cgmg_chk.sv =====
`include "color_grade_matrix_gains_macros.svh"

module cgmg_chk import cgmg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [GAIN_W-1:0] red_gain_o,
  input logic [GAIN_W-1:0] green_gain_o,
  input logic [GAIN_W-1:0] blue_gain_o,
  input logic              clear_cross_terms_o
);

  // every accepted request comes out after the fixed latency
  `CGMG_ASSERT_DELAY(a_req_gives_result, clk_i, rst_ni, start && !busy, done_o, LATENCY)
  // no result without a request the same distance back
  `CGMG_ASSERT_IMPLY(a_result_had_req, clk_i, rst_ni, done_o, $past(start && !busy, LATENCY))
  // reset flushes the pipeline
  `CGMG_ASSERT_IMPLY(a_result_after_reset, clk_i, rst_ni, done_o, $past(rst_ni, LATENCY))
  // outputs only move on a strobe
  `CGMG_ASSERT_IMPLY(a_hold_between, clk_i, rst_ni, !done_o, $stable(red_gain_o) && $stable(green_gain_o) && $stable(blue_gain_o) && $stable(clear_cross_terms_o))

endmodule

bind color_grade_matrix_gains cgmg_chk u_cgmg_chk (.*);
